@@ rtl/sos_pkg.sv @@
// shared types and constants of the stack of stacks engine
package sos_pkg;

  localparam int STACKS_DEF = 16;
  localparam int DEPTH_DEF  = 16;

  localparam int FUNC_W   = 2;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 5;

  localparam logic [FUNC_W-1:0] FUNC_PUSH_STACK = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH       = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP_STACK  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_POP        = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_OUTER_FULL  = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_STACK    = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_INNER_FULL  = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_INNER_EMPTY = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [WORD_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                has_value;
    logic [WORD_W-1:0]   value_res;
    logic [POS_W-1:0]    position;
    logic                last;
  } result_t;

  // tag that travels alongside an outstanding word memory read
  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] position;
    logic             last;
  } pend_t;

  typedef enum logic {
    S_IDLE,
    S_STREAM
  } state_t;

endpackage

@@ rtl/sos_word_mem.sv @@
// word store: single write port, single registered read port
module sos_word_mem #(
  parameter int ENTRIES = sos_pkg::STACKS_DEF * sos_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(ENTRIES)-1:0] wr_addr,
  input  logic [sos_pkg::WORD_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(ENTRIES)-1:0] rd_addr,
  output logic [sos_pkg::WORD_W-1:0] rd_data
);

  logic [sos_pkg::WORD_W-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/sos_count_mem.sv @@
// word counts of the inner stacks below the topmost one
module sos_count_mem #(
  parameter int ENTRIES = sos_pkg::STACKS_DEF,
  parameter int CW      = 5
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(ENTRIES)-1:0] wr_addr,
  input  logic [CW-1:0]              wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(ENTRIES)-1:0] rd_addr,
  output logic [CW-1:0]              rd_data
);

  logic [CW-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/sos_ctrl.sv @@
// command sequencer: top-of-stack registers, memory accesses and result register
module sos_ctrl #(
  parameter int STACKS = sos_pkg::STACKS_DEF,
  parameter int DEPTH  = sos_pkg::DEPTH_DEF,
  localparam int TW  = $clog2(STACKS),
  localparam int CW  = $clog2(DEPTH + 1),
  localparam int AW  = $clog2(STACKS * DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  sos_pkg::cmd_t              cmd,
  output logic                       strobe,
  output sos_pkg::result_t           result,
  output logic                       wr_en,
  output logic [AW-1:0]              wr_addr,
  output logic [sos_pkg::WORD_W-1:0] wr_data,
  output logic                       rd_en,
  output logic [AW-1:0]              rd_addr,
  input  logic [sos_pkg::WORD_W-1:0] rd_data,
  output logic                       cnt_wr_en,
  output logic [TW-1:0]              cnt_wr_addr,
  output logic [CW-1:0]              cnt_wr_data,
  output logic                       cnt_rd_en,
  output logic [TW-1:0]              cnt_rd_addr,
  input  logic [CW-1:0]              cnt_rd_data
);

  localparam int SCW = $clog2(STACKS + 1);

  sos_pkg::state_t  state, state_next;
  logic [SCW-1:0]   stack_count, stack_count_next;
  logic [CW-1:0]    top_count, top_count_next;
  logic [AW-1:0]    base, base_next;
  logic [AW-1:0]    rd_base, rd_base_next;
  logic [CW-1:0]    idx, idx_next;
  logic [CW-1:0]    n_pop, n_pop_next;
  logic             reload, reload_next;
  sos_pkg::pend_t   pend, pend_next;
  logic             strobe_next;
  sos_pkg::result_t result_next;

  logic          accept;
  logic [TW-1:0] top;
  logic [CW-1:0] idx_inc;

  assign busy    = (state != sos_pkg::S_IDLE) || pend.valid || reload;
  assign accept  = start && !busy;
  assign top     = TW'(stack_count - SCW'(1));
  assign idx_inc = idx + CW'(1);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sos_pkg::S_IDLE: begin
        if (accept && cmd.func == sos_pkg::FUNC_POP_STACK && stack_count != '0 &&
            top_count > CW'(1)) begin
          state_next = sos_pkg::S_STREAM;
        end
      end
      sos_pkg::S_STREAM: begin
        if (idx_inc == n_pop) begin
          state_next = sos_pkg::S_IDLE;
        end
      end
      default: state_next = sos_pkg::S_IDLE;
    endcase
  end

  // memory controls and datapath next values
  always_comb begin
    stack_count_next = stack_count;
    top_count_next   = top_count;
    base_next        = base;
    rd_base_next     = rd_base;
    idx_next         = idx;
    n_pop_next       = n_pop;
    reload_next      = 1'b0;
    pend_next        = '0;
    strobe_next      = 1'b0;
    result_next      = result;
    wr_en            = 1'b0;
    wr_addr          = base + AW'(top_count);
    wr_data          = cmd.value;
    rd_en            = 1'b0;
    rd_addr          = base;
    cnt_wr_en        = 1'b0;
    cnt_wr_addr      = top;
    cnt_wr_data      = top_count;
    cnt_rd_en        = 1'b0;
    cnt_rd_addr      = TW'(stack_count - SCW'(2));

    // word read issued last cycle is on rd_data now
    if (pend.valid) begin
      strobe_next = 1'b1;
      result_next = '{sos_pkg::STATUS_OK, 1'b1, rd_data, pend.position, pend.last};
    end

    // new top's count arrives on cnt_rd_data in the cycle after a whole-stack pop
    if (reload) begin
      top_count_next = cnt_rd_data;
    end

    unique case (state)
      sos_pkg::S_IDLE: begin
        if (accept) begin
          strobe_next = 1'b1;
          result_next = '{sos_pkg::STATUS_OK, 1'b0, '0, '0, 1'b1};
          if (cmd.func == sos_pkg::FUNC_PUSH_STACK) begin
            if (stack_count == SCW'(STACKS)) begin
              result_next.status = sos_pkg::STATUS_OUTER_FULL;
            end else begin
              cnt_wr_en        = (stack_count != '0);
              top_count_next   = '0;
              base_next        = (stack_count == '0) ? '0 : base + AW'(DEPTH);
              stack_count_next = stack_count + SCW'(1);
            end
          end else if (stack_count == '0) begin
            result_next.status = sos_pkg::STATUS_NO_STACK;
          end else begin
            unique case (cmd.func)
              sos_pkg::FUNC_PUSH: begin
                if (top_count == CW'(DEPTH)) begin
                  result_next.status = sos_pkg::STATUS_INNER_FULL;
                end else begin
                  wr_en          = 1'b1;
                  top_count_next = top_count + CW'(1);
                end
              end
              sos_pkg::FUNC_POP: begin
                if (top_count == '0) begin
                  result_next.status = sos_pkg::STATUS_INNER_EMPTY;
                end else begin
                  strobe_next    = 1'b0;
                  rd_en          = 1'b1;
                  rd_addr        = base + AW'(top_count - CW'(1));
                  pend_next      = '{1'b1, sos_pkg::POS_W'(top_count), 1'b1};
                  top_count_next = top_count - CW'(1);
                end
              end
              default: begin
                // whole-stack pop
                stack_count_next = stack_count - SCW'(1);
                base_next        = base - AW'(DEPTH);
                if (stack_count >= SCW'(2)) begin
                  cnt_rd_en   = 1'b1;
                  reload_next = 1'b1;
                end
                if (top_count != '0) begin
                  strobe_next  = 1'b0;
                  rd_en        = 1'b1;
                  pend_next    = '{1'b1, sos_pkg::POS_W'(1), top_count == CW'(1)};
                  idx_next     = CW'(1);
                  n_pop_next   = top_count;
                  rd_base_next = base;
                end
              end
            endcase
          end
        end
      end
      sos_pkg::S_STREAM: begin
        rd_en     = 1'b1;
        rd_addr   = rd_base + AW'(idx);
        pend_next = '{1'b1, sos_pkg::POS_W'(idx_inc), idx_inc == n_pop};
        idx_next  = idx_inc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sos_pkg::S_IDLE;
      stack_count <= '0;
      top_count   <= '0;
      reload      <= 1'b0;
      pend        <= '0;
      strobe      <= 1'b0;
    end else begin
      state       <= state_next;
      stack_count <= stack_count_next;
      top_count   <= top_count_next;
      reload      <= reload_next;
      pend        <= pend_next;
      strobe      <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    base    <= base_next;
    rd_base <= rd_base_next;
    idx     <= idx_next;
    n_pop   <= n_pop_next;
    result  <= result_next;
  end

  // every transaction yields a result or an outstanding read in the next cycle
  a_accept_answered: assert property (@(posedge clk) disable iff (rst)
    accept |=> (strobe || pend.valid))
    else $error("accepted transaction produced no result");

  a_pend_strobe: assert property (@(posedge clk) disable iff (rst)
    pend.valid |=> (strobe && result.has_value))
    else $error("outstanding read did not produce a result");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last) |-> (state == sos_pkg::S_IDLE))
    else $error("final result while still streaming");

  a_counts: assert property (@(posedge clk) disable iff (rst)
    (stack_count <= SCW'(STACKS)) && (top_count <= CW'(DEPTH)))
    else $error("stack counter out of range");

endmodule

@@ rtl/stack_of_stacks_engine.sv @@
// top level of the stack of stacks engine
// Commands are taken when start is high and busy is low; each result is shown
// for one cycle with strobe high and the receiver cannot stall it. Push stack,
// push word and every error case show their result in the next cycle. Pop word
// keeps busy high while the registered word memory read completes. Pop stack
// of an inner stack holding n words emits its n results on consecutive
// cycles, one word memory read per cycle; popping an empty inner stack keeps
// busy high only when a stack remains below it and its count must be
// fetched from the count memory. No clearing pass follows reset.
module stack_of_stacks_engine #(
  parameter int STACKS = sos_pkg::STACKS_DEF,
  parameter int DEPTH  = sos_pkg::DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  sos_pkg::cmd_t    cmd,
  output logic             strobe,
  output sos_pkg::result_t result
);

  localparam int TW = $clog2(STACKS);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(STACKS * DEPTH);

  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [sos_pkg::WORD_W-1:0] wr_data;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic [sos_pkg::WORD_W-1:0] rd_data;
  logic                       cnt_wr_en;
  logic [TW-1:0]              cnt_wr_addr;
  logic [CW-1:0]              cnt_wr_data;
  logic                       cnt_rd_en;
  logic [TW-1:0]              cnt_rd_addr;
  logic [CW-1:0]              cnt_rd_data;

  sos_ctrl #(
    .STACKS (STACKS),
    .DEPTH  (DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .strobe      (strobe),
    .result      (result),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .cnt_wr_en   (cnt_wr_en),
    .cnt_wr_addr (cnt_wr_addr),
    .cnt_wr_data (cnt_wr_data),
    .cnt_rd_en   (cnt_rd_en),
    .cnt_rd_addr (cnt_rd_addr),
    .cnt_rd_data (cnt_rd_data)
  );

  sos_word_mem #(
    .ENTRIES (STACKS * DEPTH)
  ) u_word_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sos_count_mem #(
    .ENTRIES (STACKS),
    .CW      (CW)
  ) u_count_mem (
    .clk     (clk),
    .wr_en   (cnt_wr_en),
    .wr_addr (cnt_wr_addr),
    .wr_data (cnt_wr_data),
    .rd_en   (cnt_rd_en),
    .rd_addr (cnt_rd_addr),
    .rd_data (cnt_rd_data)
  );

endmodule

@@ verif/stack_of_stacks_engine_tb.sv @@
// self-checking testbench of the stack of stacks engine: directed and random commands
module stack_of_stacks_engine_tb;

  localparam int STACKS       = sos_pkg::STACKS_DEF;
  localparam int DEPTH        = sos_pkg::DEPTH_DEF;
  localparam int ITEMS        = 370;
  localparam int QUIET_TAIL   = 40;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 40;

  logic             clk   = 1'b0;
  logic             rst   = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  sos_pkg::cmd_t    cmd   = '0;
  logic             strobe;
  sos_pkg::result_t result;

  stack_of_stacks_engine #(
    .STACKS(STACKS),
    .DEPTH (DEPTH)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .strobe(strobe),
    .result(result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the engine state
  int unsigned                live_stacks = 0;
  int unsigned                stack_fill [STACKS] = '{default: 0};
  logic [sos_pkg::WORD_W-1:0] stack_words [STACKS][DEPTH];

  sos_pkg::cmd_t    cmd_backlog [$];
  sos_pkg::result_t due_results [$];

  bit taken = 1'b0;
  int gap_left = 0;
  int calm_left = 0;
  int cycles = 0;
  int errors = 0;
  int items_queued = 0;
  int items_taken = 0;
  int results_checked = 0;
  int func_seen [4] = '{default: 0};
  int status_seen [8] = '{default: 0};
  int longest_dump = 0;

  task automatic emit(logic [sos_pkg::STATUS_W-1:0] status, logic has_value,
                      logic [sos_pkg::WORD_W-1:0] word, int unsigned pos, logic last);
    sos_pkg::result_t r;
    r.status    = status;
    r.has_value = has_value;
    r.value_res = word;
    r.position  = sos_pkg::POS_W'(pos);
    r.last      = last;
    due_results.push_back(r);
    status_seen[status]++;
  endtask

  // work out the results of one accepted command and update the shadow state
  task automatic forecast(sos_pkg::cmd_t c);
    int unsigned top;
    int unsigned n;
    func_seen[c.func]++;
    if (c.func == sos_pkg::FUNC_PUSH_STACK) begin
      if (live_stacks >= STACKS) begin
        emit(sos_pkg::STATUS_OUTER_FULL, 1'b0, '0, 0, 1'b1);
      end else begin
        stack_fill[live_stacks] = 0;
        live_stacks++;
        emit(sos_pkg::STATUS_OK, 1'b0, '0, 0, 1'b1);
      end
    end else if (live_stacks == 0) begin
      emit(sos_pkg::STATUS_NO_STACK, 1'b0, '0, 0, 1'b1);
    end else begin
      top = live_stacks - 1;
      n   = stack_fill[top];
      case (c.func)
        sos_pkg::FUNC_PUSH: begin
          if (n >= DEPTH) begin
            emit(sos_pkg::STATUS_INNER_FULL, 1'b0, '0, 0, 1'b1);
          end else begin
            stack_words[top][n] = c.value;
            stack_fill[top] = n + 1;
            emit(sos_pkg::STATUS_OK, 1'b0, '0, 0, 1'b1);
          end
        end
        sos_pkg::FUNC_POP_STACK: begin
          live_stacks = top;
          if (n == 0) begin
            emit(sos_pkg::STATUS_OK, 1'b0, '0, 0, 1'b1);
          end else begin
            for (int unsigned i = 0; i < n; i++)
              emit(sos_pkg::STATUS_OK, 1'b1, stack_words[top][i], i + 1, i + 1 == n);
            if (n > longest_dump) longest_dump = int'(n);
          end
        end
        default: begin
          if (n == 0) begin
            emit(sos_pkg::STATUS_INNER_EMPTY, 1'b0, '0, 0, 1'b1);
          end else begin
            emit(sos_pkg::STATUS_OK, 1'b1, stack_words[top][n-1], n, 1'b1);
            stack_fill[top] = n - 1;
          end
        end
      endcase
    end
  endtask

  task automatic check_field(string name, logic [sos_pkg::WORD_W-1:0] want,
                             logic [sos_pkg::WORD_W-1:0] got);
    if (got !== want) begin
      if (errors < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // monitor and predictor: both sample at the rising edge
  always @(posedge clk) begin
    sos_pkg::result_t want;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results still due",
               $time, cycles, due_results.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      taken = 1'b0;
      if (!rst) begin
        if (strobe) begin
          if (due_results.size() == 0) begin
            if (errors < MAX_REPORTS)
              $display("%0t: unexpected result, expected none, got %0h", $time, result);
            errors++;
          end else begin
            want = due_results.pop_front();
            check_field("status", sos_pkg::WORD_W'(want.status),
                        sos_pkg::WORD_W'(result.status));
            check_field("has_value", sos_pkg::WORD_W'(want.has_value),
                        sos_pkg::WORD_W'(result.has_value));
            check_field("value_res", want.value_res, result.value_res);
            check_field("position", sos_pkg::WORD_W'(want.position),
                        sos_pkg::WORD_W'(result.position));
            check_field("last", sos_pkg::WORD_W'(want.last),
                        sos_pkg::WORD_W'(result.last));
            results_checked++;
          end
        end
        if (start && !busy) begin
          taken = 1'b1;
          items_taken++;
          forecast(cmd);
        end
      end
    end
  end

  // driver: a presented transaction is held until it is taken
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cmd_backlog.size() == 0) begin
        start <= 1'b0;
      end else if (calm_left == 0 && cmd_backlog.size() > QUIET_TAIL &&
                   $urandom_range(0, 4) == 0) begin
        gap_left  = $urandom_range(1, 19) - 1;
        calm_left = $urandom_range(0, 25);
        start <= 1'b0;
      end else begin
        if (calm_left > 0) calm_left--;
        cmd   <= cmd_backlog.pop_front();
        start <= 1'b1;
      end
    end
  end

  task automatic queue_cmd(logic [sos_pkg::FUNC_W-1:0] func,
                           logic [sos_pkg::WORD_W-1:0] word);
    sos_pkg::cmd_t c;
    c.func  = func;
    c.value = word;
    cmd_backlog.push_back(c);
  endtask

  function automatic logic [sos_pkg::FUNC_W-1:0] pick_func(int w_ps, int w_p, int w_pss,
                                                           int w_pp);
    int r;
    r = $urandom_range(0, w_ps + w_p + w_pss + w_pp - 1);
    if (r < w_ps) return sos_pkg::FUNC_PUSH_STACK;
    if (r < w_ps + w_p) return sos_pkg::FUNC_PUSH;
    if (r < w_ps + w_p + w_pss) return sos_pkg::FUNC_POP_STACK;
    return sos_pkg::FUNC_POP;
  endfunction

  initial begin
    int s;
    int seg_len;
    int w_ps, w_p, w_pss, w_pp;

    // directed: errors with no stack, empty pops, extreme words
    queue_cmd(sos_pkg::FUNC_POP, $urandom());
    queue_cmd(sos_pkg::FUNC_PUSH, 32'h0000_0005);
    queue_cmd(sos_pkg::FUNC_POP_STACK, $urandom());
    queue_cmd(sos_pkg::FUNC_PUSH_STACK, $urandom());
    queue_cmd(sos_pkg::FUNC_POP, $urandom());
    queue_cmd(sos_pkg::FUNC_POP_STACK, $urandom());   // empty, nothing below
    queue_cmd(sos_pkg::FUNC_PUSH_STACK, $urandom());
    queue_cmd(sos_pkg::FUNC_PUSH, 32'h0000_0000);
    queue_cmd(sos_pkg::FUNC_PUSH_STACK, $urandom());
    queue_cmd(sos_pkg::FUNC_POP_STACK, $urandom());   // empty, one stack below
    queue_cmd(sos_pkg::FUNC_PUSH, 32'hFFFF_FFFF);
    queue_cmd(sos_pkg::FUNC_PUSH, 32'hA5A5_A5A5);
    queue_cmd(sos_pkg::FUNC_POP, $urandom());
    queue_cmd(sos_pkg::FUNC_POP_STACK, $urandom());
    queue_cmd(sos_pkg::FUNC_PUSH_STACK, $urandom());
    queue_cmd(sos_pkg::FUNC_PUSH, 32'h8000_0000);
    queue_cmd(sos_pkg::FUNC_PUSH, 32'h7FFF_FFFF);
    queue_cmd(sos_pkg::FUNC_POP_STACK, $urandom());
    queue_cmd(sos_pkg::FUNC_POP_STACK, $urandom());
    queue_cmd(sos_pkg::FUNC_PUSH_STACK, $urandom());
    queue_cmd(sos_pkg::FUNC_PUSH, 32'h5A5A_5A5A);
    queue_cmd(sos_pkg::FUNC_POP, $urandom());
    queue_cmd(sos_pkg::FUNC_POP, $urandom());
    queue_cmd(sos_pkg::FUNC_POP_STACK, $urandom());

    // open every stack with up to three words, fill the top one past its depth, then one stack too many
    for (s = 0; s <= STACKS; s++) begin
      queue_cmd(sos_pkg::FUNC_PUSH_STACK, $urandom());
      if (s < STACKS - 1)
        repeat ($urandom_range(0, 3)) queue_cmd(sos_pkg::FUNC_PUSH, $urandom());
      else if (s == STACKS - 1)
        repeat (DEPTH + 1) queue_cmd(sos_pkg::FUNC_PUSH, $urandom());
    end
    queue_cmd(sos_pkg::FUNC_POP_STACK, $urandom());

    // random segments, each leaning toward growth, draining, churn or noise
    while (cmd_backlog.size() < ITEMS) begin
      case ($urandom_range(0, 3))
        0:       begin w_ps = 30; w_p = 50; w_pss = 5;  w_pp = 15; end
        1:       begin w_ps = 5;  w_p = 15; w_pss = 40; w_pp = 40; end
        2:       begin w_ps = 15; w_p = 40; w_pss = 20; w_pp = 25; end
        default: begin w_ps = 25; w_p = 25; w_pss = 25; w_pp = 25; end
      endcase
      seg_len = $urandom_range(8, 30);
      repeat (seg_len) queue_cmd(pick_func(w_ps, w_p, w_pss, w_pp), $urandom());
    end
    items_queued = cmd_backlog.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (items_taken < items_queued || due_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("run covered %0d commands (push stack %0d, push word %0d, pop stack %0d,",
             items_taken, func_seen[sos_pkg::FUNC_PUSH_STACK], func_seen[sos_pkg::FUNC_PUSH],
             func_seen[sos_pkg::FUNC_POP_STACK]);
    $display("  pop word %0d), %0d results checked; errors: outer full %0d, no stack %0d,",
             func_seen[sos_pkg::FUNC_POP], results_checked,
             status_seen[sos_pkg::STATUS_OUTER_FULL], status_seen[sos_pkg::STATUS_NO_STACK]);
    $display("  inner full %0d, inner empty %0d; longest stack dump %0d words",
             status_seen[sos_pkg::STATUS_INNER_FULL], status_seen[sos_pkg::STATUS_INNER_EMPTY],
             longest_dump);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ stack_of_stacks_engine.f @@
rtl/sos_pkg.sv
rtl/sos_word_mem.sv
rtl/sos_count_mem.sv
rtl/sos_ctrl.sv
rtl/stack_of_stacks_engine.sv
verif/stack_of_stacks_engine_tb.sv
